// ===== design/wgfe_pkg.sv =====
// ----------------------------------------------------------------------------
// wgfe_pkg - shared definitions of the led gamma frame encoder
// opcodes, register indexes, reset values, slot select struct and gamma rom
// ----------------------------------------------------------------------------
package wgfe_pkg;

  // default geometry
  localparam int LED_COUNT_DEF       = 16;
  localparam int LEDS_PER_BUTTON_DEF = 2;
  localparam int RESET_SLOTS_DEF     = 64;

  localparam int BITS_PER_LED = 24;

  // duty register reset values
  localparam logic [7:0] HIGH_DUTY_RST = 8'd143;
  localparam logic [7:0] LOW_DUTY_RST  = 8'd67;

  // request opcodes
  localparam logic [1:0] OP_SET     = 2'd0;
  localparam logic [1:0] OP_REFRESH = 2'd1;
  localparam logic [1:0] OP_TICK    = 2'd2;

  // configuration register indexes
  localparam int         CFG_IDX_W     = 2;
  localparam logic [1:0] REG_HIGH_DUTY = 2'd0;
  localparam logic [1:0] REG_LOW_DUTY  = 2'd1;

  // selects one bit slot of a colour word
  typedef struct packed {
    logic       row_ok;   // colour row exists, else the led reads as black
    logic [4:0] bit_idx;  // 0..23, g r b order, msb first
  } bit_sel_t;

  localparam logic [7:0] GAMMA_ROM [256] = '{
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,
    8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd3,   8'd3,   8'd3,
    8'd4,   8'd4,   8'd4,   8'd5,   8'd5,   8'd5,   8'd6,   8'd6,
    8'd6,   8'd7,   8'd7,   8'd7,   8'd8,   8'd8,   8'd9,   8'd9,
    8'd9,   8'd10,  8'd10,  8'd11,  8'd11,  8'd12,  8'd12,  8'd13,
    8'd13,  8'd14,  8'd14,  8'd15,  8'd15,  8'd16,  8'd16,  8'd17,
    8'd17,  8'd18,  8'd19,  8'd19,  8'd20,  8'd20,  8'd21,  8'd22,
    8'd22,  8'd23,  8'd23,  8'd24,  8'd25,  8'd25,  8'd26,  8'd27,
    8'd27,  8'd28,  8'd29,  8'd29,  8'd30,  8'd31,  8'd32,  8'd32,
    8'd33,  8'd34,  8'd35,  8'd35,  8'd36,  8'd37,  8'd38,  8'd38,
    8'd39,  8'd40,  8'd41,  8'd42,  8'd42,  8'd43,  8'd44,  8'd45,
    8'd46,  8'd46,  8'd47,  8'd48,  8'd49,  8'd50,  8'd51,  8'd52,
    8'd53,  8'd53,  8'd54,  8'd55,  8'd56,  8'd57,  8'd58,  8'd59,
    8'd60,  8'd61,  8'd62,  8'd63,  8'd64,  8'd65,  8'd66,  8'd67,
    8'd68,  8'd69,  8'd70,  8'd71,  8'd72,  8'd73,  8'd74,  8'd75,
    8'd76,  8'd77,  8'd78,  8'd79,  8'd80,  8'd81,  8'd82,  8'd83,
    8'd84,  8'd85,  8'd87,  8'd88,  8'd89,  8'd90,  8'd91,  8'd92,
    8'd93,  8'd94,  8'd96,  8'd97,  8'd98,  8'd99,  8'd100, 8'd101,
    8'd103, 8'd104, 8'd105, 8'd106, 8'd107, 8'd109, 8'd110, 8'd111,
    8'd112, 8'd114, 8'd115, 8'd116, 8'd117, 8'd119, 8'd120, 8'd121,
    8'd122, 8'd124, 8'd125, 8'd126, 8'd128, 8'd129, 8'd130, 8'd131,
    8'd133, 8'd134, 8'd135, 8'd137, 8'd138, 8'd139, 8'd141, 8'd142,
    8'd144, 8'd145, 8'd146, 8'd148, 8'd149, 8'd150, 8'd152, 8'd153,
    8'd155, 8'd156, 8'd158, 8'd159, 8'd160, 8'd162, 8'd163, 8'd165,
    8'd166, 8'd168, 8'd169, 8'd171, 8'd172, 8'd174, 8'd175, 8'd177,
    8'd178, 8'd180, 8'd181, 8'd183, 8'd184, 8'd186, 8'd187, 8'd189,
    8'd190, 8'd192, 8'd193, 8'd195, 8'd196, 8'd198, 8'd200, 8'd201,
    8'd203, 8'd204, 8'd206, 8'd208, 8'd209, 8'd211, 8'd212, 8'd214,
    8'd216, 8'd217, 8'd219, 8'd221, 8'd222, 8'd224, 8'd225, 8'd227,
    8'd229, 8'd231, 8'd232, 8'd234, 8'd236, 8'd237, 8'd239, 8'd241,
    8'd242, 8'd244, 8'd246, 8'd248, 8'd249, 8'd251, 8'd253, 8'd255
  };

endpackage

// ===== design/wgfe_bit_encode.sv =====
// ----------------------------------------------------------------------------
// wgfe_bit_encode - duty value of one data bit slot
// picks the colour byte, applies the gamma rom and maps the bit to a duty
// ----------------------------------------------------------------------------
module wgfe_bit_encode (
  input  logic [23:0]        colour_i,  // red<<16 | green<<8 | blue
  input  wgfe_pkg::bit_sel_t sel_i,
  input  logic [7:0]         high_duty_i,
  input  logic [7:0]         low_duty_i,
  output logic [7:0]         duty_o
);

  localparam logic [1:0] LANE_GREEN = 2'd0;
  localparam logic [1:0] LANE_RED   = 2'd1;

  logic [7:0] raw_byte;
  logic [7:0] corr_byte;
  logic       bit_val;

  always_comb begin
    case (sel_i.bit_idx[4:3])
      LANE_GREEN: raw_byte = colour_i[15:8];
      LANE_RED:   raw_byte = colour_i[23:16];
      default:    raw_byte = colour_i[7:0];
    endcase
    if (!sel_i.row_ok) begin
      raw_byte = 8'd0;
    end
  end

  assign corr_byte = wgfe_pkg::GAMMA_ROM[raw_byte];
  // msb first within each byte
  assign bit_val   = corr_byte[3'd7 - sel_i.bit_idx[2:0]];
  assign duty_o    = bit_val ? high_duty_i : low_duty_i;

endmodule

// ===== design/ws2812_gamma_frame_encoder.sv =====
// ----------------------------------------------------------------------------
// ws2812_gamma_frame_encoder - led colour store and timer duty frame encoder
// keeps per-button colours and streams one duty value per slot tick
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries requests: tuser is the opcode (set colour, refresh, tick),
//   tdata the button index and the red, green and blue bytes.
//   m_axis returns one duty value per tick of a running frame; tuser flags
//   the last slot. cfg writes the high and low duty registers.
// frame: RESET_SLOTS zero slots, 24 bits per led (g r b, msb first, gamma
//   corrected), then RESET_SLOTS zero slots.
// handling: set, refresh and idle ticks finish in the idle state. a zero slot
//   tick emits from there; a data bit tick reads the frame store, then does
//   the rom lookup, and no request is taken until it emits. the tick that
//   starts a frame emits slot 0 and then copies the colour memory into the
//   frame memory, one row a cycle; no request is taken during the copy.
// output: a result is registered in the output register; a data bit result
//   waits in the lookup state while the output register is held.
// reset: colours read as black through per-row valid bits, duties go to
//   143 and 67, no frame runs and none is pending. no clearing pass.
// stall: a held result blocks the next request until m_axis takes it.
// ----------------------------------------------------------------------------
module ws2812_gamma_frame_encoder #(
  parameter int LED_COUNT       = wgfe_pkg::LED_COUNT_DEF,
  parameter int LEDS_PER_BUTTON = wgfe_pkg::LEDS_PER_BUTTON_DEF,
  parameter int RESET_SLOTS     = wgfe_pkg::RESET_SLOTS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // request stream
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // [2:0] button_index, [10:3] red, [18:11] green, [26:19] blue
  input  logic [31:0]                    s_axis_tdata_i,
  // [1:0] opcode
  input  logic [1:0]                     s_axis_tuser_i,
  // result stream
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [7:0] duty
  output logic [7:0]                     m_axis_tdata_o,
  // [0] frame_end
  output logic [0:0]                     m_axis_tuser_o,
  // configuration writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [wgfe_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]                     cfg_data_i
);

  // geometry: leds of a button always share one colour, so rows are buttons
  localparam int BTN_RAW     = LED_COUNT / LEDS_PER_BUTTON;
  localparam int BTN_COUNT   = (BTN_RAW > 8) ? 8 : BTN_RAW;   // 3-bit index
  localparam int ROWS        = (BTN_COUNT > 1) ? BTN_COUNT : 1;
  localparam int ROW_W       = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int GRP_N       = (LED_COUNT + LEDS_PER_BUTTON - 1) / LEDS_PER_BUTTON;
  localparam int GRP_W       = (GRP_N > 1) ? $clog2(GRP_N) : 1;
  localparam int SUB_W       = (LEDS_PER_BUTTON > 1) ? $clog2(LEDS_PER_BUTTON) : 1;
  localparam int CMP_W       = GRP_W + 4;
  localparam int BITS_END    = RESET_SLOTS + LED_COUNT * wgfe_pkg::BITS_PER_LED;
  localparam int FRAME_SLOTS = BITS_END + RESET_SLOTS;
  localparam int SLOT_W      = $clog2(FRAME_SLOTS);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LOOKUP = 2'd1;
  localparam logic [1:0] ST_COPY   = 2'd2;

  // request fields
  logic [1:0]  opcode;
  logic [2:0]  button_index;
  logic [23:0] in_colour;
  logic        in_req;
  logic        btn_ok;

  assign opcode       = s_axis_tuser_i;
  assign button_index = s_axis_tdata_i[2:0];
  // red<<16 | green<<8 | blue
  assign in_colour    = {s_axis_tdata_i[10:3], s_axis_tdata_i[18:11], s_axis_tdata_i[26:19]};
  assign btn_ok       = {1'b0, button_index} < 4'(BTN_COUNT);

  // control state
  logic [1:0]       state_q, state_d;
  logic             pending_q, pending_d;
  logic             active_q, active_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [4:0]       bit_q, bit_d;
  logic [SUB_W-1:0] sub_q, sub_d;
  logic [GRP_W-1:0] grp_q, grp_d;
  logic [ROW_W:0]   copy_idx_q, copy_idx_d;
  logic             cp_wr_q;
  logic [ROW_W-1:0] cp_wr_idx_q;
  logic             cp_val_q;
  logic             row_ok_q;
  logic [ROWS-1:0]  cvalid_q;

  // output register
  logic             out_valid_q;
  logic [7:0]       duty_q;
  logic             end_q;
  logic             out_free;

  // duty registers
  logic [7:0]       high_duty_q;
  logic [7:0]       low_duty_q;

  // memory ports
  logic             cwr_en;     // colour write from a set
  logic             crd_en;     // colour read during the copy
  logic             frd_en;     // frame read for a data bit
  logic             row_ok;
  logic [23:0]      crd_data_q;
  logic [23:0]      frd_data_q;

  // emit path
  logic             emit;
  logic             emit_end;
  logic [7:0]       emit_duty;
  logic [SLOT_W-1:0] em_slot;
  logic             in_bits;
  logic [7:0]       enc_duty;
  wgfe_pkg::bit_sel_t bit_sel;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) && out_free;
  assign in_req          = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  assign in_bits = (slot_q >= SLOT_W'(RESET_SLOTS)) && (slot_q < SLOT_W'(BITS_END));
  assign row_ok  = CMP_W'(grp_q) < CMP_W'(BTN_COUNT);

  assign bit_sel.row_ok  = row_ok_q;
  assign bit_sel.bit_idx = bit_q;

  wgfe_bit_encode u_bit_encode (
    .colour_i    (frd_data_q),
    .sel_i       (bit_sel),
    .high_duty_i (high_duty_q),
    .low_duty_i  (low_duty_q),
    .duty_o      (enc_duty)
  );

  always_comb begin
    state_d    = state_q;
    pending_d  = pending_q;
    active_d   = active_q;
    slot_d     = slot_q;
    bit_d      = bit_q;
    sub_d      = sub_q;
    grp_d      = grp_q;
    copy_idx_d = copy_idx_q;
    cwr_en     = 1'b0;
    crd_en     = 1'b0;
    frd_en     = 1'b0;
    emit       = 1'b0;
    emit_duty  = 8'd0;
    em_slot    = slot_q;
    emit_end   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_req) begin
          case (opcode)
            wgfe_pkg::OP_SET: begin
              cwr_en = btn_ok;
            end
            wgfe_pkg::OP_REFRESH: begin
              pending_d = 1'b1;
            end
            wgfe_pkg::OP_TICK: begin
              if (active_q) begin
                if (in_bits) begin
                  // data bit: fetch the row, finish in the lookup state
                  frd_en  = 1'b1;
                  state_d = ST_LOOKUP;
                end else begin
                  emit = 1'b1;
                end
              end else if (pending_q) begin
                // frame start: slot 0 is a zero slot, then snapshot colours
                pending_d  = 1'b0;
                active_d   = 1'b1;
                em_slot    = '0;
                bit_d      = '0;
                sub_d      = '0;
                grp_d      = '0;
                copy_idx_d = '0;
                state_d    = ST_COPY;
                emit       = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_LOOKUP: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_duty = enc_duty;
          state_d   = ST_IDLE;
          if (bit_q == 5'(wgfe_pkg::BITS_PER_LED - 1)) begin
            bit_d = '0;
            if (sub_q == SUB_W'(LEDS_PER_BUTTON - 1)) begin
              sub_d = '0;
              grp_d = grp_q + 1'b1;
            end else begin
              sub_d = sub_q + 1'b1;
            end
          end else begin
            bit_d = bit_q + 1'b1;
          end
        end
      end
      ST_COPY: begin
        if (copy_idx_q == (ROW_W + 1)'(ROWS)) begin
          state_d = ST_IDLE;   // last row is written at this edge
        end else begin
          crd_en     = 1'b1;
          copy_idx_d = copy_idx_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (emit) begin
      emit_end = (em_slot == SLOT_W'(FRAME_SLOTS - 1));
      if (emit_end) begin
        active_d = 1'b0;
        slot_d   = '0;
      end else begin
        slot_d   = em_slot + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pending_q   <= 1'b0;
      active_q    <= 1'b0;
      slot_q      <= '0;
      bit_q       <= '0;
      sub_q       <= '0;
      grp_q       <= '0;
      copy_idx_q  <= '0;
      cp_wr_q     <= 1'b0;
      cvalid_q    <= '0;
      out_valid_q <= 1'b0;
      high_duty_q <= wgfe_pkg::HIGH_DUTY_RST;
      low_duty_q  <= wgfe_pkg::LOW_DUTY_RST;
    end else begin
      state_q    <= state_d;
      pending_q  <= pending_d;
      active_q   <= active_d;
      slot_q     <= slot_d;
      bit_q      <= bit_d;
      sub_q      <= sub_d;
      grp_q      <= grp_d;
      copy_idx_q <= copy_idx_d;
      cp_wr_q    <= crd_en;
      if (cwr_en) begin
        cvalid_q[button_index[ROW_W-1:0]] <= 1'b1;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          wgfe_pkg::REG_HIGH_DUTY: high_duty_q <= cfg_data_i;
          wgfe_pkg::REG_LOW_DUTY:  low_duty_q  <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (emit) begin
      duty_q <= emit_duty;
      end_q  <= emit_end;
    end
    if (crd_en) begin
      cp_wr_idx_q <= copy_idx_q[ROW_W-1:0];
      cp_val_q    <= cvalid_q[copy_idx_q[ROW_W-1:0]];
    end
    if (frd_en) begin
      row_ok_q <= row_ok;
    end
  end

  // colour memory: written by sets, read by the copy sweep
  logic [23:0] colour_mem [ROWS];

  always_ff @(posedge clk_i) begin
    if (cwr_en) begin
      colour_mem[button_index[ROW_W-1:0]] <= in_colour;
    end
    if (crd_en) begin
      crd_data_q <= colour_mem[copy_idx_q[ROW_W-1:0]];
    end
  end

  // frame memory: written by the copy sweep, read per data bit
  logic [23:0] frame_mem [ROWS];

  always_ff @(posedge clk_i) begin
    if (cp_wr_q) begin
      frame_mem[cp_wr_idx_q] <= cp_val_q ? crd_data_q : 24'd0;
    end
    if (frd_en) begin
      frd_data_q <= frame_mem[grp_q[ROW_W-1:0]];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = duty_q;
  assign m_axis_tuser_o  = end_q;

`ifndef SYNTHESIS
  // the last slot is always in the tail
  a_end_is_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |-> m_axis_tdata_o == 8'd0)
    else $error("frame end slot carries a nonzero duty");

  // a bit lookup only happens inside a running frame
  a_lookup_active : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LOOKUP |-> active_q)
    else $error("bit lookup outside a frame");

  // frame rows are never read while the copy still writes them
  a_no_read_during_copy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    frd_en |-> !cp_wr_q && state_q != ST_COPY)
    else $error("frame memory read overlaps the copy");

  // the final slot closes the frame
  a_end_closes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && emit_end |=> !active_q && slot_q == '0)
    else $error("frame still active after its last slot");

  a_slot_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= SLOT_W'(FRAME_SLOTS - 1))
    else $error("slot counter out of range");
`endif

endmodule
